@@ rtl/secded_pkg.sv @@
`timescale 1ns / 1ps

package secded_pkg;

  localparam int CwBits   = 72;
  localparam int DataBits = 64;
  localparam int SynBits  = 7;
  localparam int OutBits  = 16;

  typedef enum logic [1:0] {
    MODE_ENCODE = 2'd0,
    MODE_CHECK  = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_FIXED = 2'd1,
    CLS_FAIL  = 2'd2
  } cls_e;

  typedef struct packed {
    logic [CwBits-1:0]   code;
    logic [DataBits-1:0] data;
    cls_e                cls;
    logic [SynBits-1:0]  pos;
  } res_t;

  typedef struct packed {
    logic  fire;
    logic  check;
    logic  clear;
    cls_e  cls;
  } cnt_evt_t;

endpackage

@@ rtl/secded_codec.sv @@
`timescale 1ns / 1ps

module secded_codec import secded_pkg::*; (
  input  logic [1:0]          mode_i,
  input  logic [CwBits-1:0]   word_i,
  output res_t                res_o
);

  function automatic logic is_par(int p);
    return (p & (p - 1)) == 0;
  endfunction

  function automatic logic [SynBits-1:0] syndrome(logic [CwBits-1:0] cw);
    logic [SynBits-1:0] s;
    s = '0;
    for (int n = 0; n < SynBits; n++) begin
      for (int p = 0; p < CwBits; p++) begin
        if (((p >> n) & 1) != 0) s[n] = s[n] ^ cw[p];
      end
    end
    return s;
  endfunction

  function automatic logic [DataBits-1:0] extract(logic [CwBits-1:0] cw);
    logic [DataBits-1:0] d;
    int m;
    d = '0;
    m = 0;
    for (int p = 0; p < CwBits; p++) begin
      if (!is_par(p)) begin
        d[m] = cw[p];
        m++;
      end
    end
    return d;
  endfunction

  function automatic logic [CwBits-1:0] place(logic [DataBits-1:0] d);
    logic [CwBits-1:0] cw;
    int m;
    cw = '0;
    m = 0;
    for (int p = 0; p < CwBits; p++) begin
      if (!is_par(p)) begin
        cw[p] = d[m];
        m++;
      end
    end
    return cw;
  endfunction

  logic [CwBits-1:0]  placed, enc, fix;
  logic [SynBits-1:0] syn_e, syn_c;
  logic               par_c, in_range;
  cls_e               cls;

  // encode: syndrome bits go to power-of-two positions, bit 0 evens out the rest
  always_comb begin
    placed = place(word_i[DataBits-1:0]);
    syn_e  = syndrome(placed);
    enc    = placed;
    for (int n = 0; n < SynBits; n++) begin
      enc[1 << n] = syn_e[n];
    end
    enc[0] = ^enc[CwBits-1:1];
  end

  always_comb begin
    syn_c    = syndrome(word_i);
    par_c    = ^word_i;
    in_range = syn_c < SynBits'(CwBits);
    if (!par_c && syn_c == '0) begin
      cls = CLS_NONE;
    end else if (par_c && in_range) begin
      cls = CLS_FIXED;
    end else begin
      cls = CLS_FAIL;
    end
    for (int p = 0; p < CwBits; p++) begin
      fix[p] = word_i[p] ^ (cls == CLS_FIXED && syn_c == SynBits'(p));
    end
  end

  always_comb begin
    res_o = '0;
    case (mode_i)
      MODE_ENCODE: begin
        res_o.code = enc;
      end
      MODE_CHECK: begin
        res_o.code = fix;
        res_o.data = extract(fix);
        res_o.cls  = cls;
        res_o.pos  = (cls == CLS_FIXED) ? syn_c : '0;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

@@ rtl/secded_counters.sv @@
`timescale 1ns / 1ps

module secded_counters import secded_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cnt_evt_t           evt_i,
  output logic [OutBits-1:0] error_total_o,
  output logic [OutBits-1:0] corrected_total_o,
  output logic [OutBits-1:0] uncorrected_total_o
);

  logic [COUNT_WIDTH-1:0] any_q, any_d, fixed_q, fixed_d, fail_q, fail_d;

  function automatic logic [COUNT_WIDTH-1:0] bump(logic [COUNT_WIDTH-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  always_comb begin
    any_d   = any_q;
    fixed_d = fixed_q;
    fail_d  = fail_q;
    if (evt_i.fire) begin
      if (evt_i.clear) begin
        any_d   = '0;
        fixed_d = '0;
        fail_d  = '0;
      end else if (evt_i.check) begin
        if (evt_i.cls != CLS_NONE)  any_d   = bump(any_q);
        if (evt_i.cls == CLS_FIXED) fixed_d = bump(fixed_q);
        if (evt_i.cls == CLS_FAIL)  fail_d  = bump(fail_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q   <= '0;
      fixed_q <= '0;
      fail_q  <= '0;
    end else begin
      any_q   <= any_d;
      fixed_q <= fixed_d;
      fail_q  <= fail_d;
    end
  end

  // values after this transfer
  assign error_total_o       = OutBits'(any_d);
  assign corrected_total_o   = OutBits'(fixed_d);
  assign uncorrected_total_o = OutBits'(fail_d);

endmodule

@@ rtl/secded_72_64_codec_scrubber.sv @@
`timescale 1ns / 1ps

// SECDED 72/64 codec and scrubber.
// Slave stream: tuser selects encode, check/correct or counter clear; tdata
// carries the 64-bit message (encode) or the 72-bit codeword (check).
// Master stream: one transfer per input transfer, carrying the encoded or
// corrected codeword, extracted data, error position and the three
// saturating scrub counters as they stand after that item; tuser holds the
// error class (none, corrected, uncorrectable).
// One input register, then the encode/syndrome XOR trees and the counter
// update feed the output register. Throughput is one item per cycle while
// the receiver is ready. When the receiver stalls, the output register
// holds its transfer and the input register fills, after which
// s_axis_tready drops; no item is lost.
// Reset clears both valid flags and all counters to zero.
module secded_72_64_codec_scrubber import secded_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,  // word_low[63:0], word_high[71:64]
  input  logic [1:0]   s_axis_tuser,  // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // code_low[63:0], code_high[71:64], data_out[135:72], error_position[142:136],
  // error_total[158:143], corrected_total[174:159], uncorrected_total[190:175]
  output logic [191:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser   // error_class
);

  logic              in_valid_q, out_valid_q, adv;
  logic [1:0]        in_mode_q;
  logic [CwBits-1:0] in_word_q;
  res_t              res;
  cnt_evt_t          evt;
  logic [OutBits-1:0] err_tot, fix_tot, fail_tot;
  logic [191:0]      out_data_q;
  logic [1:0]        out_user_q;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode_q <= s_axis_tuser;
      in_word_q <= s_axis_tdata;
    end
  end

  secded_codec u_codec (
    .mode_i (in_mode_q),
    .word_i (in_word_q),
    .res_o  (res)
  );

  assign evt.fire  = adv;
  assign evt.check = in_mode_q == MODE_CHECK;
  assign evt.clear = in_mode_q == MODE_CLEAR;
  assign evt.cls   = res.cls;

  secded_counters #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_counters (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .evt_i               (evt),
    .error_total_o       (err_tot),
    .corrected_total_o   (fix_tot),
    .uncorrected_total_o (fail_tot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {1'b0, fail_tot, fix_tot, err_tot, res.pos, res.data, res.code};
      out_user_q <= res.cls;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

@@ bench/secded_72_64_codec_scrubber_tb.sv @@
`timescale 1ns / 1ps

module secded_72_64_codec_scrubber_tb;
  import secded_pkg::*;

  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam logic [15:0] CntMax = 16'hFFFF;
  localparam int CycleLimit = 200000;
  localparam int ItemsPerPhase = 125;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] lo;
    logic [7:0]  hi;
  } scrub_req_t;

  typedef struct packed {
    logic [71:0] code;
    logic [63:0] data;
    cls_e        cls;
    logic [6:0]  pos;
    logic [15:0] err_cnt;
    logic [15:0] fix_cnt;
    logic [15:0] unf_cnt;
  } scrub_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;  // word_low[63:0], word_high[71:64]
  logic [1:0]   s_axis_tuser = '0;  // mode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // code_low, code_high, data_out, error_position, error_total, corrected_total,
  // uncorrected_total
  logic [191:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;       // error_class

  scrub_req_t    pending_words_q[$];
  scrub_result_t predicted_results_q[$];
  scrub_req_t    in_flight;
  logic [15:0]   any_err_cnt, fixed_cnt, unfixed_cnt;
  int            idle_pct, stall_pct;
  int            mismatch_cnt;
  int            cycle_cnt;

  secded_72_64_codec_scrubber #(.COUNT_WIDTH(16)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [71:0] secded_encode(input logic [63:0] msg);
    logic [71:0] cw;
    logic [6:0]  syn;
    int          m;
    cw = '0;
    syn = '0;
    m = 0;
    for (int p = 1; p < 72; p++) begin
      if ((p & (p - 1)) != 0) begin
        cw[p] = msg[m];
        if (msg[m]) syn ^= 7'(p);
        m++;
      end
    end
    for (int n = 0; n < 7; n++) cw[1 << n] = syn[n];
    cw[0] = ^cw[71:1];
    return cw;
  endfunction

  function automatic logic [63:0] secded_extract(input logic [71:0] cw);
    logic [63:0] d;
    int          m;
    d = '0;
    m = 0;
    for (int p = 1; p < 72; p++) begin
      if ((p & (p - 1)) != 0) begin
        d[m] = cw[p];
        m++;
      end
    end
    return d;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    return (c == CntMax) ? c : c + 16'd1;
  endfunction

  function automatic scrub_result_t predict_scrub(input scrub_req_t req);
    scrub_result_t res;
    logic [71:0]   cw;
    int            syn;
    bit            par;
    res = '0;
    res.cls = CLS_NONE;
    case (req.mode)
      MODE_ENCODE: begin
        res.code = secded_encode(req.lo);
      end
      MODE_CHECK: begin
        cw = {req.hi, req.lo};
        syn = 0;
        par = 1'b0;
        for (int p = 0; p < 72; p++) begin
          if (cw[p]) begin
            syn ^= p;
            par ^= 1'b1;
          end
        end
        if (!par && syn == 0) begin
          res.cls = CLS_NONE;
        end else if (par && syn < 72) begin
          res.cls = CLS_FIXED;
          res.pos = 7'(syn);
          cw[syn] = ~cw[syn];
        end else begin
          res.cls = CLS_FAIL;
        end
        res.code = cw;
        res.data = secded_extract(cw);
        if (res.cls != CLS_NONE) any_err_cnt = sat_inc(any_err_cnt);
        if (res.cls == CLS_FIXED) fixed_cnt = sat_inc(fixed_cnt);
        if (res.cls == CLS_FAIL) unfixed_cnt = sat_inc(unfixed_cnt);
      end
      MODE_CLEAR: begin
        any_err_cnt = '0;
        fixed_cnt = '0;
        unfixed_cnt = '0;
      end
      default: begin
      end
    endcase
    if (req.mode != MODE_CLEAR) begin
      res.err_cnt = any_err_cnt;
      res.fix_cnt = fixed_cnt;
      res.unf_cnt = unfixed_cnt;
    end
    return res;
  endfunction

  task automatic push_word(input logic [1:0] mode, input logic [63:0] lo, input logic [7:0] hi);
    scrub_req_t req;
    req.mode = mode;
    req.lo = lo;
    req.hi = hi;
    pending_words_q.push_back(req);
  endtask

  task automatic push_check(input logic [71:0] cw);
    push_word(MODE_CHECK, cw[63:0], cw[71:64]);
  endtask

  function automatic logic [71:0] flip_bits(input logic [71:0] cw, input int k);
    for (int i = 0; i < k; i++) cw[$urandom_range(71)] ^= 1'b1;
    return cw;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_random_item();
    int          roll;
    logic [63:0] msg;
    logic [71:0] cw;
    roll = $urandom_range(99);
    msg = rand64();
    if (roll < 3) begin
      push_word(MODE_CLEAR, rand64(), 8'($urandom));
    end else if (roll < 6) begin
      push_word(MODE_NOP, rand64(), 8'($urandom));
    end else if (roll < 22) begin
      push_word(MODE_ENCODE, msg, 8'($urandom));
    end else if (roll < 32) begin
      push_check({8'($urandom), rand64()});
    end else begin
      cw = secded_encode(msg);
      push_check(flip_bits(cw, $urandom_range(3)));
    end
  endtask

  task automatic report_mismatch(input string field, input logic [71:0] got,
                                 input logic [71:0] want);
    $display("%0t: %s mismatch, got %h expected %h", $time, field, got, want);
    mismatch_cnt++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predicted_results_q.push_back(predict_scrub(in_flight));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_flight = pending_words_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {in_flight.hi, in_flight.lo};
          s_axis_tuser <= in_flight.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    scrub_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_results_q.size() == 0) begin
          report_mismatch("unexpected transfer", m_axis_tdata[71:0], '0);
        end else begin
          want = predicted_results_q.pop_front();
          if (m_axis_tdata[71:0] !== want.code)
            report_mismatch("codeword", m_axis_tdata[71:0], want.code);
          if (m_axis_tdata[135:72] !== want.data)
            report_mismatch("data_out", 72'(m_axis_tdata[135:72]), 72'(want.data));
          if (m_axis_tuser !== want.cls)
            report_mismatch("error_class", 72'(m_axis_tuser), 72'(want.cls));
          if (m_axis_tdata[142:136] !== want.pos)
            report_mismatch("error_position", 72'(m_axis_tdata[142:136]), 72'(want.pos));
          if (m_axis_tdata[158:143] !== want.err_cnt)
            report_mismatch("error_total", 72'(m_axis_tdata[158:143]), 72'(want.err_cnt));
          if (m_axis_tdata[174:159] !== want.fix_cnt)
            report_mismatch("corrected_total", 72'(m_axis_tdata[174:159]),
                            72'(want.fix_cnt));
          if (m_axis_tdata[190:175] !== want.unf_cnt)
            report_mismatch("uncorrected_total", 72'(m_axis_tdata[190:175]),
                            72'(want.unf_cnt));
        end
      end
      m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("secded_72_64_codec_scrubber_tb: done, errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_words_q.size() > 0 || s_axis_tvalid || predicted_results_q.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic [71:0] cw;
    any_err_cnt = '0;
    fixed_cnt = '0;
    unfixed_cnt = '0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_word(MODE_ENCODE, '0, '0);
    push_word(MODE_ENCODE, '1, 8'hFF);
    push_word(MODE_ENCODE, 64'd1, 8'h00);
    push_word(MODE_ENCODE, 64'h8000_0000_0000_0000, 8'h5A);
    push_word(MODE_ENCODE, 64'hAAAA_AAAA_AAAA_AAAA, 8'hA5);
    push_check(secded_encode('1));
    push_check('0);
    push_check('1);
    cw = secded_encode(64'h0123_4567_89AB_CDEF);
    push_check(cw ^ (72'd1 << 0));
    push_check(cw ^ (72'd1 << 71));
    push_check(cw ^ (72'd1 << 64));
    push_check(cw ^ (72'd1 << 3));
    push_check(cw ^ (72'd1 << 5) ^ (72'd1 << 40));
    // odd weight, syndrome 72: beyond the last position
    push_check((72'd1 << 0) | (72'd1 << 8) | (72'd1 << 64));
    push_check({8'hFF, 64'h5555_5555_5555_5555});
    push_word(MODE_CLEAR, '1, 8'hFF);
    push_check(cw ^ (72'd1 << 17));
    push_word(MODE_NOP, 64'hDEAD_BEEF_0000_FFFF, 8'hC3);
    push_word(MODE_NOP, '1, 8'hFF);
    push_check(flip_bits(secded_encode(rand64()), 2));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      for (int i = 0; i < ItemsPerPhase; i++) push_random_item();
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (predicted_results_q.size() > 0)
      report_mismatch("missing transfers", '0, 72'(predicted_results_q.size()));
    if (mismatch_cnt == 0) begin
      $display("secded_72_64_codec_scrubber_tb: done, clean");
    end else begin
      $display("secded_72_64_codec_scrubber_tb: done, errors");
    end
    $finish;
  end

endmodule
